// ===== src/mgb_pkg.sv =====
// shared types and constants for the masked gaussian blur core
package mgb_pkg;

	localparam int DIM_BITS    = 11;
	localparam int RAD_BITS    = 2;
	localparam int WEIGHT_BITS = 16;
	localparam int ROW_BITS    = 11;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_W0     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_W1     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_W2     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_W3     = 3'd6;

	// input kinds
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// drain counter value at which the last tap is accumulated and the drain ends
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAPS,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic take;
		logic tap_start;
		logic tap_run;
		logic div_start;
		logic div_run;
		logic load_res;
	} cmd_t;

	typedef struct packed {
		logic ready;
		logic err;
		logic pass;
		logic taps_last;
		logic div_last;
	} sts_t;

endpackage

// ===== src/mgb_ctrl.sv =====
// sequencing state machine of the masked gaussian blur core
module mgb_ctrl import mgb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   out_free,
	input  sts_t   sts,
	output logic   in_ready,
	output cmd_t   cmd
);

	state_t     state_q, state_n;
	logic [1:0] cnt_q;

	// state register and drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_DRAIN) begin
				cnt_q <= cnt_q + 2'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.ready) begin
					state_n = ST_IDLE;
				end else if (sts.err) begin
					state_n = ST_RESULT;
				end else begin
					cmd.tap_start = 1'b1;
					state_n       = ST_TAPS;
				end
			end
			ST_TAPS: begin
				cmd.tap_run = 1'b1;
				if (sts.taps_last) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == DRAIN_LAST) begin
					state_n = ST_PREP;
				end
			end
			ST_PREP: begin
				if (sts.pass) begin
					state_n = ST_RESULT;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_last) begin
					state_n = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load_res = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/mgb_dpath.sv =====
// line store, position counters, tap pipeline and divider of the blur core
module mgb_dpath import mgb_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cmd_t                                  cmd,
	output sts_t                                  sts,
	input  logic                                  func,
	input  logic signed [PIXEL_BITS-1:0]          pixel,
	input  logic                                  missing,
	input  logic [DIM_BITS-1:0]                   cfg_width,
	input  logic [DIM_BITS-1:0]                   cfg_height,
	input  logic [RAD_BITS-1:0]                   cfg_radius,
	input  logic [3:0][WEIGHT_BITS-1:0]           cfg_weight,
	output logic signed [PIXEL_BITS-1:0]          res_value,
	output logic                                  res_last,
	output logic                                  res_err
);

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int RING_ROWS = 2 * MAX_RADIUS + 3;
	localparam int RB        = $clog2(RING_ROWS);
	localparam int RW        = $clog2(MAX_RADIUS + 1);
	localparam int KW        = $clog2(2 * MAX_RADIUS + 1);
	localparam int PW        = ((CW > ROW_BITS) ? CW : ROW_BITS) + 2;
	localparam int AW        = RB + CW;
	localparam int MDEPTH    = RING_ROWS * (1 << CW);
	localparam int W2        = 2 * WEIGHT_BITS;
	localparam int PRODW     = W2 + 1 + PIXEL_BITS;
	localparam int SUMW      = PRODW + 6;
	localparam int UW        = W2 + 6;
	localparam int NUMW      = SUMW + 1;
	localparam int DCW       = $clog2(PIXEL_BITS + 2);

	// frame geometry and position state
	logic [CW:0]          fw_q, fw_n, fw_c;
	logic [ROW_BITS-1:0]  fh_q, fh_n, fh_c;
	logic [RW-1:0]        fr_q, fr_n;
	logic                 active_q, done_q, done_c;
	logic [CW-1:0]        col_q, ocol_q;
	logic [ROW_BITS-1:0]  row_q, orow_q;
	logic [RB-1:0]        in_ring_q, out_ring_q;
	logic [CW+1:0]        rx;
	logic [ROW_BITS:0]    ry;
	logic                 last_pos;
	logic                 mem_we;

	// tap sequencing
	logic [KW-1:0]        ky_q, kx_q, kmax;
	logic signed [PW-1:0] dy, dx, ty, tx, ady, adx;
	logic signed [RB+1:0] rr;
	logic                 ty_ok, tx_ok;

	// tap pipeline
	logic                  v_s1, v_s2, v_s3;
	logic                  ok_s1, ok_s2, ok_s3;
	logic [AW-1:0]         addr_s1;
	logic [WEIGHT_BITS-1:0] wy_s1, wx_s1;
	logic [PIXEL_BITS:0]   rd_s2;
	logic [W2-1:0]         w2d_s2, w_s3;
	logic signed [PRODW-1:0] prod_s3;
	logic signed [PIXEL_BITS-1:0] pix_s3;
	logic signed [SUMW-1:0] sum_q;
	logic [UW-1:0]         used_q;
	logic signed [PIXEL_BITS-1:0] pass_val_q;

	// divider
	logic [NUMW-1:0]       rem_q, dsh_q;
	logic [PIXEL_BITS:0]   quo_q;
	logic [DCW-1:0]        dcnt_q;

	logic [PIXEL_BITS:0]   mem [MDEPTH];

	function automatic logic [WEIGHT_BITS-1:0] wlook(input logic [PW-1:0] d);
		logic [WEIGHT_BITS-1:0] w;
		unique case (int'(d))
			0:       w = cfg_weight[0];
			1:       w = cfg_weight[1];
			2:       w = cfg_weight[2];
			3:       w = cfg_weight[3];
			default: w = '0;
		endcase
		return w;
	endfunction

	// geometry taken at the first pixel of a frame
	always_comb begin
		if (cfg_width == '0) begin
			fw_n = (CW+1)'(1);
		end else if (int'(cfg_width) > MAX_WIDTH) begin
			fw_n = (CW+1)'(MAX_WIDTH);
		end else begin
			fw_n = (CW+1)'(cfg_width);
		end
		fh_n = (cfg_height == '0) ? ROW_BITS'(1) : ROW_BITS'(cfg_height);
		fr_n = (int'(cfg_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius);
		fw_c   = active_q ? fw_q : fw_n;
		fh_c   = active_q ? fh_q : fh_n;
		done_c = active_q && done_q;
		mem_we = cmd.take && (func == FUNC_PIXEL) && !done_c;
	end

	// readiness of the next output, its flags and sequencing status
	always_comb begin
		rx = (CW+2)'(ocol_q) + (CW+2)'(fr_q);
		if (rx > (CW+2)'(fw_q - 1'b1)) begin
			rx = (CW+2)'(fw_q - 1'b1);
		end
		ry = (ROW_BITS+1)'(orow_q) + (ROW_BITS+1)'(fr_q);
		if (ry > (ROW_BITS+1)'(fh_q - 1'b1)) begin
			ry = (ROW_BITS+1)'(fh_q - 1'b1);
		end
		last_pos = ((CW+1)'(ocol_q) == fw_q - 1'b1) && (orow_q == fh_q - 1'b1);
		sts.ready = active_q && (done_q || ((ROW_BITS+1)'(row_q) > ry) ||
			(((ROW_BITS+1)'(row_q) == ry) && ((CW+2)'(col_q) > rx)));
		sts.err  = ((CW+1)'(fr_q) >= fw_q) || (ROW_BITS'(fr_q) >= fh_q);
		sts.pass = (fr_q == '0);
		sts.taps_last = (ky_q == kmax) && (kx_q == kmax);
		sts.div_last  = (dcnt_q == DCW'(PIXEL_BITS));
	end

	// position counters and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= (CW+1)'(1);
			fh_q       <= ROW_BITS'(1);
			fr_q       <= '0;
			active_q   <= 1'b0;
			done_q     <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			in_ring_q  <= '0;
			ocol_q     <= '0;
			orow_q     <= '0;
			out_ring_q <= '0;
		end else if (cmd.take) begin
			if ((func == FUNC_PIXEL) && !active_q) begin
				fw_q     <= fw_n;
				fh_q     <= fh_n;
				fr_q     <= fr_n;
				active_q <= 1'b1;
				done_q   <= 1'b0;
			end
			if (mem_we) begin
				if ((CW+1)'(col_q) + 1'b1 >= fw_c) begin
					col_q     <= '0;
					row_q     <= row_q + 1'b1;
					in_ring_q <= (in_ring_q == RB'(RING_ROWS - 1)) ? '0 : in_ring_q + 1'b1;
					if ((ROW_BITS+1)'(row_q) + 1'b1 >= (ROW_BITS+1)'(fh_c)) begin
						done_q <= 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end else if (cmd.load_res) begin
			if (last_pos) begin
				active_q   <= 1'b0;
				done_q     <= 1'b0;
				col_q      <= '0;
				row_q      <= '0;
				in_ring_q  <= '0;
				ocol_q     <= '0;
				orow_q     <= '0;
				out_ring_q <= '0;
			end else if ((CW+1)'(ocol_q) + 1'b1 >= fw_q) begin
				ocol_q     <= '0;
				orow_q     <= orow_q + 1'b1;
				out_ring_q <= (out_ring_q == RB'(RING_ROWS - 1)) ? '0 : out_ring_q + 1'b1;
			end else begin
				ocol_q <= ocol_q + 1'b1;
			end
		end
	end

	// tap offsets, bounds and ring row
	always_comb begin
		kmax  = KW'({fr_q, 1'b0});
		dy    = PW'(ky_q) - PW'(fr_q);
		dx    = PW'(kx_q) - PW'(fr_q);
		ty    = PW'(orow_q) + dy;
		tx    = PW'(ocol_q) + dx;
		ty_ok = !ty[PW-1] && ($unsigned(ty) < PW'(fh_q));
		tx_ok = !tx[PW-1] && ($unsigned(tx) < PW'(fw_q));
		ady   = dy[PW-1] ? -dy : dy;
		adx   = dx[PW-1] ? -dx : dx;
		rr    = (RB+2)'(out_ring_q) + (RB+2)'(dy);
		if (rr[RB+1]) begin
			rr = rr + (RB+2)'(RING_ROWS);
		end else if (rr >= (RB+2)'(RING_ROWS)) begin
			rr = rr - (RB+2)'(RING_ROWS);
		end
	end

	// tap counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ky_q <= '0;
			kx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.tap_run;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.tap_start) begin
				ky_q <= '0;
				kx_q <= '0;
			end else if (cmd.tap_run) begin
				if (kx_q == kmax) begin
					kx_q <= '0;
					ky_q <= ky_q + 1'b1;
				end else begin
					kx_q <= kx_q + 1'b1;
				end
			end
		end
	end

	// line store: write on accepted pixel, registered read for taps
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[{in_ring_q, col_q}] <= {missing, pixel};
		end
		rd_s2 <= mem[addr_s1];
	end

	// tap pipeline payload: address, weight product, pixel product
	always_ff @(posedge clk) begin
		addr_s1 <= {rr[RB-1:0], tx[CW-1:0]};
		ok_s1   <= ty_ok && tx_ok;
		wy_s1   <= wlook(ady);
		wx_s1   <= wlook(adx);
		ok_s2   <= ok_s1;
		w2d_s2  <= wy_s1 * wx_s1;
		ok_s3   <= ok_s2 && !rd_s2[PIXEL_BITS];
		w_s3    <= w2d_s2;
		pix_s3  <= $signed(rd_s2[PIXEL_BITS-1:0]);
		prod_s3 <= $signed({1'b0, w2d_s2}) * $signed(rd_s2[PIXEL_BITS-1:0]);
	end

	// accumulation and long division
	always_ff @(posedge clk) begin
		if (cmd.tap_start) begin
			sum_q  <= '0;
			used_q <= '0;
		end else if (v_s3 && ok_s3) begin
			sum_q  <= sum_q + SUMW'(prod_s3);
			used_q <= used_q + UW'(w_s3);
		end
		if (v_s3) begin
			pass_val_q <= ok_s3 ? pix_s3 : '0;
		end
		if (cmd.div_start) begin
			rem_q  <= (NUMW'($unsigned(sum_q)) << 1) + NUMW'(used_q);
			dsh_q  <= NUMW'({used_q, 1'b0}) << PIXEL_BITS;
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_run) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[PIXEL_BITS-1:0], 1'b1};
			end else begin
				quo_q <= {quo_q[PIXEL_BITS-1:0], 1'b0};
			end
			dsh_q  <= dsh_q >> 1;
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	// result value selection
	always_comb begin
		res_last = last_pos;
		res_err  = sts.err;
		if (sts.err) begin
			res_value = '0;
		end else if (sts.pass) begin
			res_value = pass_val_q;
		end else if ((sum_q <= 0) || (used_q == '0)) begin
			res_value = '0;
		end else if (quo_q[PIXEL_BITS] || quo_q[PIXEL_BITS-1]) begin
			res_value = {1'b0, {(PIXEL_BITS-1){1'b1}}};
		end else begin
			res_value = $signed(quo_q[PIXEL_BITS-1:0]);
		end
	end

endmodule

// ===== src/masked_gaussian_blur_core.sv =====
// top level of the masked gaussian blur core: registers, output stage, blocks
//
//  channel   dir  beat fields (lowest bit first)
//  s_axis    in   tdata: pixel | tuser: func, missing
//  m_axis    out  tdata: value | tlast: last_pixel | tuser: size_error
//  cfg       in   cfg_index, cfg_data (register write)
//
// a beat that gives no output passes IDLE and CHECK only; an output beat for radius r
// above zero passes CHECK, TAPS, DRAIN, PREP, DIV and RESULT, its length set by the
// single tap pipeline reading one window tap a cycle and the bit-serial divider
// radius zero skips DIV, and a size error goes from CHECK straight to RESULT
// arst_n clears control state; the line store holds garbage until written
// a finished output waits in the output register while the next beat is taken
module masked_gaussian_blur_core import mgb_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3,
	parameter int PIXEL_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]    s_tdata,   // pixel
	input  logic [1:0]                         s_tuser,   // func, missing
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((PIXEL_BITS+7)/8)*8-1:0]    m_tdata,   // value
	output logic                               m_tlast,
	output logic                               m_tuser,   // size_error
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]            cfg_index,
	input  logic [CFG_DATA_BITS-1:0]           cfg_data
);

	localparam int TDW = ((PIXEL_BITS + 7) / 8) * 8;

	logic [DIM_BITS-1:0]         width_q, height_q;
	logic [RAD_BITS-1:0]         radius_q;
	logic [3:0][WEIGHT_BITS-1:0] weight_q;
	logic                        out_valid_q, out_last_q, out_err_q;
	logic [PIXEL_BITS-1:0]       out_value_q;
	logic signed [PIXEL_BITS-1:0] res_value;
	logic                        res_last, res_err, out_free;
	cmd_t                        cmd;
	sts_t                        sts;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(64);
			height_q <= DIM_BITS'(64);
			radius_q <= RAD_BITS'(1);
			weight_q <= {16'd0, 16'd0, 16'd16384, 16'd32768};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q     <= cfg_data[DIM_BITS-1:0];
				REG_HEIGHT: height_q    <= cfg_data[DIM_BITS-1:0];
				REG_RADIUS: radius_q    <= cfg_data[RAD_BITS-1:0];
				REG_W0:     weight_q[0] <= cfg_data;
				REG_W1:     weight_q[1] <= cfg_data;
				REG_W2:     weight_q[2] <= cfg_data;
				REG_W3:     weight_q[3] <= cfg_data;
				default:    ;
			endcase
		end
	end

	// output register
	assign out_free = !out_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			out_value_q <= res_value;
			out_last_q  <= res_last;
			out_err_q   <= res_err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDW'(out_value_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	mgb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	mgb_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (s_tuser[0]),
		.pixel      ($signed(s_tdata[PIXEL_BITS-1:0])),
		.missing    (s_tuser[1]),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.cfg_radius (radius_q),
		.cfg_weight (weight_q),
		.res_value  (res_value),
		.res_last   (res_last),
		.res_err    (res_err)
	);

endmodule

// ===== src/mgb_checker.sv =====
// port-level checks for the masked gaussian blur core, bound to the top level
module mgb_checker #(
	parameter int PIXEL_BITS = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [((PIXEL_BITS+7)/8)*8-1:0] m_tdata,
	input logic                            m_tuser
);

	// a stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// a size error always carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[PIXEL_BITS-1:0] == '0))
		else $error("size error with non-zero value");

	// one input beat is worked on at a time
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

endmodule

bind masked_gaussian_blur_core mgb_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mgb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== bench/tb_masked_gaussian_blur_core.sv =====
// self-checking testbench for the masked gaussian blur core
module tb_masked_gaussian_blur_core import mgb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W     = 1024;
	localparam int MAX_R     = 3;
	localparam int RING_ROWS = 2 * MAX_R + 3;
	localparam int IDLE_GAP  = 120;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic        func;
		logic [15:0] pixel;
		logic        missing;
	} pix_beat_t;

	typedef struct packed {
		logic [15:0] value;
		logic        last_pixel;
		logic        size_error;
	} blur_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	pix_beat_t beat_q[$];
	blur_out_t blur_expected_q[$];
	int        mismatches = 0;
	bit        calm = 1'b0;
	int        s_gap = 0;
	int        m_gap = 0;
	int        quiet_cycles = 0;

	// predictor state
	logic [15:0] reg_file [7];
	logic signed [15:0] ring_pix [RING_ROWS*MAX_W];
	bit          ring_miss [RING_ROWS*MAX_W];
	int unsigned col_in, row_in, col_out, row_out;
	int unsigned geo_w, geo_h, geo_r;
	bit          frame_on, input_done;

	masked_gaussian_blur_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int unsigned ring_slot(int unsigned row, int unsigned col);
		return (row % RING_ROWS) * MAX_W + (col % MAX_W);
	endfunction

	function automatic longint unsigned tap_weight(int d);
		if (d > 3) return 0;
		return longint'(reg_file[REG_W0 + d]);
	endfunction

	// normalised convolution at one output position
	function automatic logic [15:0] blur_at(int ox, int oy);
		longint          acc;
		longint unsigned used;
		longint unsigned w;
		longint unsigned q;
		int              tx, ty, r;
		int unsigned     s;
		acc = 0;
		used = 0;
		r = int'(geo_r);
		for (int ky = -r; ky <= r; ky++) begin
			ty = oy + ky;
			if (ty < 0 || ty >= int'(geo_h)) continue;
			for (int kx = -r; kx <= r; kx++) begin
				tx = ox + kx;
				if (tx < 0 || tx >= int'(geo_w)) continue;
				s = ring_slot(ty, tx);
				if (ring_miss[s]) continue;
				w = tap_weight(ky < 0 ? -ky : ky) * tap_weight(kx < 0 ? -kx : kx);
				used += w;
				acc += longint'(w) * longint'(ring_pix[s]);
			end
		end
		if (acc <= 0 || used == 0) return 16'd0;
		q = (longint'(acc) * 2 + used) / (used * 2);
		if (q > 32767) q = 32767;
		return q[15:0];
	endfunction

	// advances the blur predictor by one input beat
	task automatic predict_blur(pix_beat_t b);
		int unsigned rx, ry, s;
		longint unsigned need, have;
		blur_out_t res;
		if (b.func == FUNC_PIXEL) begin
			if (!frame_on) begin
				geo_w = reg_file[REG_WIDTH] & 16'h7ff;
				if (geo_w == 0) geo_w = 1;
				if (geo_w > MAX_W) geo_w = MAX_W;
				geo_h = reg_file[REG_HEIGHT] & 16'h7ff;
				if (geo_h == 0) geo_h = 1;
				geo_r = reg_file[REG_RADIUS] & 16'h3;
				frame_on = 1; input_done = 0;
				col_in = 0; row_in = 0; col_out = 0; row_out = 0;
			end
			if (!input_done) begin
				s = ring_slot(row_in, col_in);
				ring_pix[s] = b.pixel;
				ring_miss[s] = b.missing;
				col_in++;
				if (col_in >= geo_w) begin
					col_in = 0;
					row_in++;
					if (row_in >= geo_h) input_done = 1;
				end
			end
		end
		if (!frame_on) return;
		rx = col_out + geo_r; if (rx > geo_w - 1) rx = geo_w - 1;
		ry = row_out + geo_r; if (ry > geo_h - 1) ry = geo_h - 1;
		need = longint'(ry) * geo_w + rx;
		have = longint'(row_in) * geo_w + col_in;
		if (!input_done && have <= need) return;
		res.size_error = (geo_r >= geo_w) || (geo_r >= geo_h);
		if (res.size_error) begin
			res.value = 16'd0;
		end else if (geo_r == 0) begin
			s = ring_slot(row_out, col_out);
			res.value = ring_miss[s] ? 16'd0 : ring_pix[s];
		end else begin
			res.value = blur_at(col_out, row_out);
		end
		res.last_pixel = (col_out == geo_w - 1) && (row_out == geo_h - 1);
		blur_expected_q.push_back(res);
		col_out++;
		if (col_out >= geo_w) begin
			col_out = 0;
			row_out++;
		end
		if (res.last_pixel) begin
			frame_on = 0; input_done = 0;
		end
	endtask

	// pixel source driver
	always @(posedge clk or negedge arst_n) begin
		pix_beat_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_gap > 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (beat_q.size() > 0) begin
				b = beat_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= b.pixel;
				s_tuser <= {b.missing, b.func};
				if (!calm && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 3);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_gap = 0;
		end else if (m_gap > 0) begin
			m_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 4) == 0) m_gap = $urandom_range(1, 3);
		end
	end

	// prediction on each accepted input beat, checking on each result beat
	always @(posedge clk) begin
		pix_beat_t b;
		blur_out_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				b.func = s_tuser[0];
				b.missing = s_tuser[1];
				b.pixel = s_tdata;
				predict_blur(b);
			end
			if (m_tvalid && m_tready) begin
				if (blur_expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat value=%h last=%b err=%b",
							m_tdata, m_tlast, m_tuser);
				end else begin
					want = blur_expected_q.pop_front();
					if (m_tdata !== want.value || m_tlast !== want.last_pixel ||
							m_tuser !== want.size_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected value=%h last=%b err=%b, got %h %b %b",
								want.value, want.last_pixel, want.size_error,
								m_tdata, m_tlast, m_tuser);
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic wait_beats_gone();
		do @(negedge clk); while (beat_q.size() != 0 || s_tvalid);
	endtask

	task automatic wait_quiet();
		wait_beats_gone();
		do @(negedge clk); while (blur_expected_q.size() != 0);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_file[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_pixel(bit negative);
		logic [15:0] p;
		case ($urandom_range(0, 7))
			0: p = 16'h8000;
			1: p = 16'h7fff;
			2: p = 16'h0000;
			default: p = 16'($urandom());
		endcase
		if (negative) p[15] = 1'b1;
		return p;
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom());
		endcase
	endfunction

	// one frame: settings, pixels with a few flushes mixed in, then draining
	task automatic run_frame(int w, int h, int r, logic [15:0] w0, logic [15:0] w1,
			logic [15:0] w2, logic [15:0] w3, bit negative, int miss_pct);
		int n;
		pix_beat_t b;
		wait_quiet();
		write_reg(REG_WIDTH, 16'(w));
		write_reg(REG_HEIGHT, 16'(h));
		write_reg(REG_RADIUS, 16'(r));
		write_reg(REG_W0, w0);
		write_reg(REG_W1, w1);
		write_reg(REG_W2, w2);
		write_reg(REG_W3, w3);
		n = (w == 0 ? 1 : (w > MAX_W ? MAX_W : w)) * (h == 0 ? 1 : h);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 9) == 0) begin
				b.func = FUNC_FLUSH; b.pixel = 16'($urandom()); b.missing = 1'($urandom());
				beat_q.push_back(b);
			end
			b.func = FUNC_PIXEL;
			b.pixel = pick_pixel(negative);
			b.missing = ($urandom_range(0, 99) < miss_pct);
			beat_q.push_back(b);
		end
		wait_beats_gone();
		// drain: flush ticks, now and then a stray pixel that gets dropped
		while (frame_on) begin
			b.func = ($urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_FLUSH;
			b.pixel = 16'($urandom());
			b.missing = 1'($urandom());
			beat_q.push_back(b);
			wait_beats_gone();
		end
	endtask

	initial begin
		int pix_total;
		int w, h;
		pix_beat_t b;
		reg_file = '{16'd64, 16'd64, 16'd1, 16'd32768, 16'd16384, 16'd0, 16'd0};
		frame_on = 0; input_done = 0;
		geo_w = 1; geo_h = 1; geo_r = 0;
		col_in = 0; row_in = 0; col_out = 0; row_out = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// flush with no frame under way
		b.func = FUNC_FLUSH; b.pixel = 16'hffff; b.missing = 1'b1;
		beat_q.push_back(b);
		// directed frames
		run_frame(3, 3, 1, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 0, 25);
		run_frame(4, 2, 0, 16'h8000, 16'h4000, 16'h0000, 16'h0000, 0, 30);
		run_frame(3, 3, 1, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 0, 0);
		run_frame(3, 3, 2, 16'h8000, 16'h4000, 16'h2000, 16'h1000, 1, 10);
		run_frame(2, 2, 3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 20);
		run_frame(0, 0, 2, 16'h1234, 16'h0001, 16'h0000, 16'hffff, 0, 0);
		run_frame(7, 7, 3, 16'h4000, 16'h3000, 16'h2000, 16'h1000, 0, 15);
		run_frame(40, 1, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 10);
		run_frame(0, 30, 3, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 0, 10);

		// random frames, mostly small
		pix_total = 0;
		while (pix_total < 440) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
			h = $urandom_range(1, 8);
			if (pix_total > 340) calm = 1'b1;
			run_frame(w, h, $urandom_range(0, 3), pick_weight(), pick_weight(), pick_weight(),
				pick_weight(), $urandom_range(0, 5) == 0, $urandom_range(0, 40));
			pix_total += w * h;
		end

		wait_beats_gone();
		do @(negedge clk); while (blur_expected_q.size() != 0);
		repeat (IDLE_GAP) @(posedge clk);
		if (mismatches == 0 && blur_expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== masked_gaussian_blur_core.f =====
src/mgb_pkg.sv
src/mgb_ctrl.sv
src/mgb_dpath.sv
src/masked_gaussian_blur_core.sv
src/mgb_checker.sv
bench/tb_masked_gaussian_blur_core.sv
